// File: sv/sdspi_pkg.sv
// Package for the SD card SPI-mode block sequencer.
// Holds phase, action and status codes, protocol constants, the result
// record and the command byte helpers. No dependencies.
`timescale 1ns / 1ps

package sdspi_pkg;

  // Block geometry and polling limits.
  localparam int BLOCK_BYTES = 512;
  localparam int POLL_READS  = 9;
  localparam int CNT_W       = $clog2(BLOCK_BYTES + 1);
  localparam int POLL_W      = $clog2(POLL_READS + 1);

  // Sequence lengths in bytes.
  localparam int INIT_CLOCK_BYTES = 10;
  localparam int CMD_BYTES        = 6;
  localparam int W_PRE_BYTES      = 4;
  localparam int CRC_BYTES        = 2;

  // Byte values on the bus.
  localparam logic [7:0]  BYTE_IDLE   = 8'hFF;
  localparam logic [7:0]  BYTE_ZERO   = 8'h00;
  localparam logic [7:0]  TOKEN_START = 8'hFE;
  localparam logic [7:0]  CMD_PREFIX  = 8'h40;
  localparam logic [7:0]  CRC_CMD0    = 8'h95;
  localparam logic [31:0] CMD1_ARG    = 32'h00FF_C000;
  localparam logic [7:0]  R1_IDLE     = 8'h01;
  localparam logic [7:0]  R1_READY    = 8'h00;

  // Data response token, low nibble.
  localparam logic [3:0] DRESP_ACCEPTED = 4'h5;
  localparam logic [3:0] DRESP_CRC_ERR  = 4'hB;

  // Command indexes.
  localparam logic [5:0] CMD0  = 6'h00;
  localparam logic [5:0] CMD1  = 6'h01;
  localparam logic [5:0] CMD17 = 6'h11;
  localparam logic [5:0] CMD24 = 6'h18;

  typedef enum logic [1:0] {
    ACT_DONE  = 2'd0,
    ACT_INIT  = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_RESP  = 2'd1,
    ST_CRC_ERR   = 2'd2,
    ST_BAD_DRESP = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_INIT_CLK = 4'd1,
    PH_CMD      = 4'd2,
    PH_RESP     = 4'd3,
    PH_INIT_GAP = 4'd4,
    PH_W_PRE    = 4'd5,
    PH_W_DATA   = 4'd6,
    PH_W_CRC    = 4'd7,
    PH_W_DRESP  = 4'd8,
    PH_W_BUSY   = 4'd9,
    PH_TAIL     = 4'd10,
    PH_R_WAIT   = 4'd11,
    PH_R_DATA   = 4'd12,
    PH_R_CRC    = 4'd13
  } phase_t;

  // One result transaction.
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       chip_select_n;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       payload_taken;
    logic       finished;
    status_t    status;
  } result_t;

  // Result that requests one more exchange.
  function automatic result_t request(input logic [7:0] tx, input logic cs_n);
    result_t r;
    r               = '0;
    r.tx_byte       = tx;
    r.tx_valid      = 1'b1;
    r.chip_select_n = cs_n;
    return r;
  endfunction

  // Byte k of a command frame: index byte, four argument bytes, CRC.
  function automatic logic [7:0] cmd_byte(input logic [5:0] code,
                                          input logic [31:0] addr,
                                          input logic [2:0] k);
    logic [31:0] arg;
    logic [7:0]  b;
    if (code == CMD0) begin
      arg = 32'h0;
    end else if (code == CMD1) begin
      arg = CMD1_ARG;
    end else begin
      arg = addr;
    end
    case (k)
      3'd0:    b = CMD_PREFIX | {2'b00, code};
      3'd1:    b = arg[31:24];
      3'd2:    b = arg[23:16];
      3'd3:    b = arg[15:8];
      3'd4:    b = arg[7:0];
      default: b = (code == CMD0) ? CRC_CMD0 : BYTE_IDLE;
    endcase
    return b;
  endfunction

endpackage

// File: sv/sd_spi_block_sequencer.sv
// Top level of the SD card SPI-mode block sequencer.
// Depends on sdspi_pkg for codes, constants and the result record.
`timescale 1ns / 1ps

// Byte-level host sequencer for an SD card in SPI mode.
// Each input transaction reports the end of one SPI byte exchange (or starts
// init, block write or block read) and yields exactly one result
// transaction: the next byte to send with its chip select level, a received
// block data byte when one is kept, whether the write payload byte was used,
// and the completion status of the operation.
// A start action abandons any running operation and begins the new one.
// The result of an accepted transaction is registered and shows on the
// out_ channel in the next cycle. One transaction is accepted per clock while
// the result register is not stalled; the state update and the result are one
// combinational pass into the result register. In a system, each transaction
// stands for one byte exchange, so the serial shifter sets the real pace.
// When the receiver stalls, the held result stays on the out_ ports and
// in_stall rises until it is taken; no result is dropped.
// Synchronous reset empties the result register, returns the sequencer to
// idle and sets the held chip select level high (deasserted).
module sd_spi_block_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_block_address,
  input  logic [9:0]  in_payload_length,
  input  logic [7:0]  in_miso_byte,
  input  logic [7:0]  in_payload_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_tx_byte,
  output logic        out_tx_valid,
  output logic        out_chip_select_n,
  output logic [7:0]  out_read_byte,
  output logic        out_read_valid,
  output logic        out_payload_taken,
  output logic        out_finished,
  output logic [1:0]  out_status
);

  localparam int CW = sdspi_pkg::CNT_W;
  localparam int PW = sdspi_pkg::POLL_W;

  sdspi_pkg::phase_t  phase_r, phase_nxt;
  sdspi_pkg::action_t operation_r, operation_nxt;
  logic [CW-1:0]      byte_count_r, byte_count_nxt;
  logic [PW-1:0]      poll_count_r, poll_count_nxt;
  logic [CW-1:0]      op_length_r, op_length_nxt;
  logic [31:0]        op_address_r, op_address_nxt;
  logic [3:0]         data_token_r, data_token_nxt;
  logic [5:0]         cmd_code_r, cmd_code_nxt;
  logic               cs_level_r, cs_level_nxt;
  sdspi_pkg::result_t out_r, res;
  logic               out_valid_r, out_valid_nxt;
  logic               accept;
  sdspi_pkg::action_t act;

  assign act      = sdspi_pkg::action_t'(in_action);
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  // Next state and the result for the transaction on the input ports.
  always_comb begin
    phase_nxt      = phase_r;
    operation_nxt  = operation_r;
    byte_count_nxt = byte_count_r;
    poll_count_nxt = poll_count_r;
    op_length_nxt  = op_length_r;
    op_address_nxt = op_address_r;
    data_token_nxt = data_token_r;
    cmd_code_nxt   = cmd_code_r;
    res               = '0;
    res.chip_select_n = cs_level_r;

    if (act != sdspi_pkg::ACT_DONE) begin
      // A start always wins, even over a running operation.
      operation_nxt  = act;
      op_address_nxt = in_block_address;
      if ({22'd0, in_payload_length} > 32'(sdspi_pkg::BLOCK_BYTES)) begin
        op_length_nxt = CW'(sdspi_pkg::BLOCK_BYTES);
      end else begin
        op_length_nxt = CW'(in_payload_length);
      end
      data_token_nxt = '0;
      poll_count_nxt = '0;
      byte_count_nxt = '0;
      if (act == sdspi_pkg::ACT_INIT) begin
        phase_nxt = sdspi_pkg::PH_INIT_CLK;
        res       = sdspi_pkg::request(sdspi_pkg::BYTE_IDLE, 1'b1);
      end else begin
        cmd_code_nxt = (act == sdspi_pkg::ACT_WRITE) ? sdspi_pkg::CMD24 : sdspi_pkg::CMD17;
        phase_nxt    = sdspi_pkg::PH_CMD;
        res          = sdspi_pkg::request(
                         sdspi_pkg::cmd_byte(cmd_code_nxt, in_block_address, 3'd0), 1'b0);
      end
    end else begin
      case (phase_r)
        sdspi_pkg::PH_INIT_CLK: begin
          // Wake-up clocks with chip select high, then CMD0.
          byte_count_nxt = byte_count_r + 1'b1;
          if (byte_count_nxt < CW'(sdspi_pkg::INIT_CLOCK_BYTES)) begin
            res = sdspi_pkg::request(sdspi_pkg::BYTE_IDLE, 1'b1);
          end else begin
            cmd_code_nxt   = sdspi_pkg::CMD0;
            phase_nxt      = sdspi_pkg::PH_CMD;
            byte_count_nxt = '0;
            res            = sdspi_pkg::request(
                               sdspi_pkg::cmd_byte(sdspi_pkg::CMD0, op_address_r, 3'd0), 1'b0);
          end
        end
        sdspi_pkg::PH_CMD: begin
          byte_count_nxt = byte_count_r + 1'b1;
          if (byte_count_nxt < CW'(sdspi_pkg::CMD_BYTES)) begin
            res = sdspi_pkg::request(
                    sdspi_pkg::cmd_byte(cmd_code_r, op_address_r, byte_count_nxt[2:0]), 1'b0);
          end else begin
            phase_nxt      = sdspi_pkg::PH_RESP;
            poll_count_nxt = '0;
            res            = sdspi_pkg::request(sdspi_pkg::BYTE_IDLE, 1'b0);
          end
        end
        sdspi_pkg::PH_RESP: begin
          // Poll for the R1 response; the last byte read counts.
          poll_count_nxt = poll_count_r + 1'b1;
          if (in_miso_byte == sdspi_pkg::R1_READY || in_miso_byte == sdspi_pkg::R1_IDLE ||
              poll_count_nxt >= PW'(sdspi_pkg::POLL_READS)) begin
            if (cmd_code_r == sdspi_pkg::CMD0) begin
              if (in_miso_byte != sdspi_pkg::R1_IDLE) begin
                phase_nxt    = sdspi_pkg::PH_IDLE;
                res.finished = 1'b1;
                res.status   = sdspi_pkg::ST_BAD_RESP;
              end else begin
                phase_nxt = sdspi_pkg::PH_INIT_GAP;
                res       = sdspi_pkg::request(sdspi_pkg::BYTE_IDLE, 1'b1);
              end
            end else if (cmd_code_r == sdspi_pkg::CMD1) begin
              phase_nxt = (in_miso_byte == sdspi_pkg::R1_IDLE) ? sdspi_pkg::PH_INIT_GAP
                                                                : sdspi_pkg::PH_TAIL;
              res       = sdspi_pkg::request(sdspi_pkg::BYTE_IDLE, 1'b1);
            end else if (in_miso_byte != sdspi_pkg::R1_READY) begin
              phase_nxt    = sdspi_pkg::PH_IDLE;
              res.finished = 1'b1;
              res.status   = sdspi_pkg::ST_BAD_RESP;
            end else if (cmd_code_r == sdspi_pkg::CMD24) begin
              phase_nxt      = sdspi_pkg::PH_W_PRE;
              byte_count_nxt = '0;
              res            = sdspi_pkg::request(sdspi_pkg::BYTE_IDLE, 1'b0);
            end else begin
              phase_nxt = sdspi_pkg::PH_R_WAIT;
              res       = sdspi_pkg::request(sdspi_pkg::BYTE_IDLE, 1'b0);
            end
          end else begin
            res = sdspi_pkg::request(sdspi_pkg::BYTE_IDLE, 1'b0);
          end
        end
        sdspi_pkg::PH_INIT_GAP: begin
          cmd_code_nxt   = sdspi_pkg::CMD1;
          phase_nxt      = sdspi_pkg::PH_CMD;
          byte_count_nxt = '0;
          res            = sdspi_pkg::request(
                             sdspi_pkg::cmd_byte(sdspi_pkg::CMD1, op_address_r, 3'd0), 1'b0);
        end
        sdspi_pkg::PH_W_PRE: begin
          // Gap bytes, then the start token, then the first payload byte.
          byte_count_nxt = byte_count_r + 1'b1;
          if (byte_count_nxt < CW'(sdspi_pkg::W_PRE_BYTES)) begin
            res = sdspi_pkg::request(
                    (byte_count_nxt == CW'(sdspi_pkg::W_PRE_BYTES - 1)) ?
                    sdspi_pkg::TOKEN_START : sdspi_pkg::BYTE_IDLE, 1'b0);
          end else begin
            phase_nxt      = sdspi_pkg::PH_W_DATA;
            byte_count_nxt = '0;
            if (op_length_r != '0) begin
              res               = sdspi_pkg::request(in_payload_byte, 1'b0);
              res.payload_taken = 1'b1;
            end else begin
              res = sdspi_pkg::request(sdspi_pkg::BYTE_ZERO, 1'b0);
            end
          end
        end
        sdspi_pkg::PH_W_DATA: begin
          // Payload bytes, zero padded past the requested length.
          byte_count_nxt = byte_count_r + 1'b1;
          if (byte_count_nxt < CW'(sdspi_pkg::BLOCK_BYTES)) begin
            if (byte_count_nxt < op_length_r) begin
              res               = sdspi_pkg::request(in_payload_byte, 1'b0);
              res.payload_taken = 1'b1;
            end else begin
              res = sdspi_pkg::request(sdspi_pkg::BYTE_ZERO, 1'b0);
            end
          end else begin
            phase_nxt      = sdspi_pkg::PH_W_CRC;
            byte_count_nxt = '0;
            res            = sdspi_pkg::request(sdspi_pkg::BYTE_IDLE, 1'b0);
          end
        end
        sdspi_pkg::PH_W_CRC: begin
          byte_count_nxt = byte_count_r + 1'b1;
          if (byte_count_nxt >= CW'(sdspi_pkg::CRC_BYTES)) begin
            phase_nxt = sdspi_pkg::PH_W_DRESP;
          end
          res = sdspi_pkg::request(sdspi_pkg::BYTE_IDLE, 1'b0);
        end
        sdspi_pkg::PH_W_DRESP: begin
          data_token_nxt = in_miso_byte[3:0];
          phase_nxt      = sdspi_pkg::PH_W_BUSY;
          res            = sdspi_pkg::request(sdspi_pkg::BYTE_IDLE, 1'b0);
        end
        sdspi_pkg::PH_W_BUSY: begin
          // The card holds the line at zero while it programs.
          if (in_miso_byte == sdspi_pkg::BYTE_ZERO) begin
            res = sdspi_pkg::request(sdspi_pkg::BYTE_IDLE, 1'b0);
          end else begin
            phase_nxt = sdspi_pkg::PH_TAIL;
            res       = sdspi_pkg::request(sdspi_pkg::BYTE_IDLE, 1'b1);
          end
        end
        sdspi_pkg::PH_TAIL: begin
          phase_nxt    = sdspi_pkg::PH_IDLE;
          res.finished = 1'b1;
          if (operation_r == sdspi_pkg::ACT_WRITE) begin
            if (data_token_r == sdspi_pkg::DRESP_ACCEPTED) begin
              res.status = sdspi_pkg::ST_OK;
            end else if (data_token_r == sdspi_pkg::DRESP_CRC_ERR) begin
              res.status = sdspi_pkg::ST_CRC_ERR;
            end else begin
              res.status = sdspi_pkg::ST_BAD_DRESP;
            end
          end else begin
            res.status = sdspi_pkg::ST_OK;
          end
        end
        sdspi_pkg::PH_R_WAIT: begin
          if (in_miso_byte == sdspi_pkg::TOKEN_START) begin
            phase_nxt      = sdspi_pkg::PH_R_DATA;
            byte_count_nxt = '0;
          end
          res = sdspi_pkg::request(sdspi_pkg::BYTE_IDLE, 1'b0);
        end
        sdspi_pkg::PH_R_DATA: begin
          // Keep the first bytes of the block, read the rest through.
          res = sdspi_pkg::request(sdspi_pkg::BYTE_IDLE, 1'b0);
          if (byte_count_r < op_length_r) begin
            res.read_byte  = in_miso_byte;
            res.read_valid = 1'b1;
          end
          byte_count_nxt = byte_count_r + 1'b1;
          if (byte_count_nxt >= CW'(sdspi_pkg::BLOCK_BYTES)) begin
            phase_nxt      = sdspi_pkg::PH_R_CRC;
            byte_count_nxt = '0;
          end
        end
        sdspi_pkg::PH_R_CRC: begin
          byte_count_nxt = byte_count_r + 1'b1;
          if (byte_count_nxt < CW'(sdspi_pkg::CRC_BYTES)) begin
            res = sdspi_pkg::request(sdspi_pkg::BYTE_IDLE, 1'b0);
          end else begin
            phase_nxt = sdspi_pkg::PH_TAIL;
            res       = sdspi_pkg::request(sdspi_pkg::BYTE_IDLE, 1'b1);
          end
        end
        default: begin
          // Idle: an exchange report changes nothing.
          phase_nxt = sdspi_pkg::PH_IDLE;
        end
      endcase
    end

    // The held chip select level follows every result.
    cs_level_nxt = res.chip_select_n;
  end

  // Result register handshake.
  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Sequencer state, updated on each accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= sdspi_pkg::PH_IDLE;
      operation_r  <= sdspi_pkg::ACT_DONE;
      byte_count_r <= '0;
      poll_count_r <= '0;
      op_length_r  <= '0;
      op_address_r <= '0;
      data_token_r <= '0;
      cmd_code_r   <= '0;
      cs_level_r   <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        phase_r      <= phase_nxt;
        operation_r  <= operation_nxt;
        byte_count_r <= byte_count_nxt;
        poll_count_r <= poll_count_nxt;
        op_length_r  <= op_length_nxt;
        op_address_r <= op_address_nxt;
        data_token_r <= data_token_nxt;
        cmd_code_r   <= cmd_code_nxt;
        cs_level_r   <= cs_level_nxt;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_tx_byte       = out_r.tx_byte;
  assign out_tx_valid      = out_r.tx_valid;
  assign out_chip_select_n = out_r.chip_select_n;
  assign out_read_byte     = out_r.read_byte;
  assign out_read_valid    = out_r.read_valid;
  assign out_payload_taken = out_r.payload_taken;
  assign out_finished      = out_r.finished;
  assign out_status        = out_r.status;

endmodule

// File: sv/sdspi_checker.sv
// Port-level assertions for the SD card SPI-mode block sequencer.
// Bound to sd_spi_block_sequencer; uses no package.
`timescale 1ns / 1ps

module sdspi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_tx_byte,
  input logic        out_tx_valid,
  input logic        out_finished,
  input logic [1:0]  out_status
);

  // A held result keeps its byte while the receiver stalls.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tx_byte))
    else $error("stalled result changed");

  // Each accepted transaction shows a result on the next cycle.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted transaction produced no result");

  // The input side only stalls behind a blocked result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  // A finished operation requests no further exchange.
  a_finish_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_finished |-> !out_tx_valid && out_tx_byte == 8'h00)
    else $error("exchange requested with finish");

  // Status is zero unless the operation ends.
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_finished |-> out_status == 2'd0)
    else $error("status set on an unfinished result");

endmodule

bind sd_spi_block_sequencer sdspi_checker u_sdspi_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_tx_byte  (out_tx_byte),
  .out_tx_valid (out_tx_valid),
  .out_finished (out_finished),
  .out_status   (out_status)
);
